// ----- rtl/pixel_brightness_contrast_macros.svh -----
// Assertion helpers for the checker file.
`ifndef PIXEL_BRIGHTNESS_CONTRAST_MACROS_SVH
`define PIXEL_BRIGHTNESS_CONTRAST_MACROS_SVH

// Checked on every clock edge outside reset.
`define PBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/pbc_pkg.sv -----
`timescale 1ns / 1ps
package pbc_pkg;

    localparam int DEF_MAX_DIMENSION  = 4096;
    localparam int DEF_FRACTION_BITS  = 16;
    localparam int FACTOR_INT_BITS    = 10;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int OFFS_W     = 9;
    localparam int LEVEL_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // 259*(c+255) fits 18 bits, 255*(259-c) fits 17 bits
    localparam int NUMER_BASE_W = 18;
    localparam int DEN_W        = 17;

    localparam int CONTRAST_NUM_K = 259;
    localparam int CONTRAST_DEN_K = 255;
    localparam logic [PIX_W-1:0] MID_LEVEL = 8'd128;
    localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_CONTRAST   = 2'd1,
        CFG_WIDTH      = 2'd2,
        CFG_HEIGHT     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_red;
        logic [PIX_W-1:0]   pixel_green;
        logic [PIX_W-1:0]   pixel_blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
    } t_pix_out;

endpackage

// ----- rtl/pbc_stream_if.sv -----
`timescale 1ns / 1ps
interface pbc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/pbc_factor_div.sv -----
`timescale 1ns / 1ps
module pbc_factor_div #(
    parameter int FRACTION_BITS = pbc_pkg::DEF_FRACTION_BITS
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_start,
    input  logic [pbc_pkg::LEVEL_W-1:0]                       i_level,
    output logic                                              o_busy,
    output logic [pbc_pkg::FACTOR_INT_BITS+FRACTION_BITS-1:0] o_factor
);

    localparam int FW    = pbc_pkg::FACTOR_INT_BITS + FRACTION_BITS;
    localparam int NB_W  = pbc_pkg::NUMER_BASE_W;
    localparam int DEN_W = pbc_pkg::DEN_W;
    localparam int NUM_W = NB_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [FW-1:0]    r_factor;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic signed [pbc_pkg::LEVEL_W:0] lvl_ext;
    logic                             lvl_low;
    logic                             lvl_high;
    logic [pbc_pkg::LEVEL_W:0]        c_plus;
    logic [pbc_pkg::LEVEL_W:0]        c_minus;
    logic [NB_W-1:0]                  numer_base;
    logic [DEN_W-1:0]                 den_val;
    logic [DEN_W:0]                   trial;
    logic [DEN_W:0]                   diff;
    logic                             ge;
    logic [DEN_W-1:0]                 n_rem;
    logic [NUM_W-1:0]                 n_num;
    logic [FW-1:0]                    n_factor;

    always_comb begin
        lvl_ext    = $signed({i_level[pbc_pkg::LEVEL_W-1], i_level});
        lvl_low    = $signed(i_level) <= -10'sd255;
        lvl_high   = $signed(i_level) >= 10'sd259;
        c_plus     = (pbc_pkg::LEVEL_W+1)'(lvl_ext + 11'sd255);
        c_minus    = (pbc_pkg::LEVEL_W+1)'(11'sd259 - lvl_ext);
        numer_base = NB_W'(c_plus[pbc_pkg::LEVEL_W-1:0] * NB_W'(pbc_pkg::CONTRAST_NUM_K));
        den_val    = DEN_W'(c_minus[pbc_pkg::LEVEL_W-1:0] * DEN_W'(pbc_pkg::CONTRAST_DEN_K));

        // restoring division, one quotient bit per cycle
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_num = {r_num[NUM_W-2:0], ge};

        if (|n_num[NUM_W-1:FW]) begin
            n_factor = '1;
        end else begin
            n_factor = n_num[FW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_factor <= FW'(1) << FRACTION_BITS;
        end else if (i_start) begin
            if (lvl_low) begin
                r_factor <= '0;
                r_busy   <= 1'b0;
            end else if (lvl_high) begin
                r_factor <= '1;
                r_busy   <= 1'b0;
            end else begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy   <= 1'b0;
                r_factor <= n_factor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {numer_base, {FRACTION_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= den_val;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_busy   = r_busy;
    assign o_factor = r_factor;

endmodule

// ----- rtl/pbc_chan_contrast.sv -----
`timescale 1ns / 1ps
module pbc_chan_contrast #(
    parameter int FRACTION_BITS = pbc_pkg::DEF_FRACTION_BITS
) (
    input  logic [pbc_pkg::PIX_W-1:0]                         i_value,
    input  logic [pbc_pkg::FACTOR_INT_BITS+FRACTION_BITS-1:0] i_factor,
    output logic [pbc_pkg::PIX_W-1:0]                         o_value
);

    localparam int FW = pbc_pkg::FACTOR_INT_BITS + FRACTION_BITS;
    localparam int PW = FW + pbc_pkg::PIX_W;
    localparam int SW = PW + 1 - FRACTION_BITS;
    localparam logic [PW:0] ROUND_UP = {{(PW+1-FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}};

    logic                     neg;
    logic [pbc_pkg::PIX_W-1:0] mag;
    logic [PW-1:0]            prod;
    logic [PW:0]              biased;
    logic [SW-1:0]            shifted;

    always_comb begin
        neg = ~i_value[pbc_pkg::PIX_W-1];
        if (neg) begin
            mag = pbc_pkg::PIX_W'({1'b0, pbc_pkg::MID_LEVEL} - {1'b0, i_value});
        end else begin
            mag = {1'b0, i_value[pbc_pkg::PIX_W-2:0]};
        end
        prod = PW'(i_factor) * PW'(mag);
        // below mid level the magnitude rounds up, so the signed result floors
        biased  = {1'b0, prod} + (neg ? ROUND_UP : '0);
        shifted = biased[PW:FRACTION_BITS];

        if (!neg) begin
            if (shifted > SW'(127)) begin
                o_value = pbc_pkg::PIX_MAX;
            end else begin
                o_value = {1'b1, shifted[pbc_pkg::PIX_W-2:0]};
            end
        end else begin
            if (shifted > SW'(128)) begin
                o_value = '0;
            end else begin
                o_value = pbc_pkg::PIX_W'({1'b0, pbc_pkg::MID_LEVEL} - shifted[pbc_pkg::PIX_W:0]);
            end
        end
    end

endmodule

// ----- rtl/pixel_brightness_contrast.sv -----
`timescale 1ns / 1ps
// Brightness and contrast adjustment, one RGB pixel per clock when not stalled.
// i_pix (sink) takes a pixel with its column and row; o_pix (source) gives the
// adjusted channels, one result per request, in order. Both are valid/ready.
// Pixels on the outer one-pixel frame (or outside the image) pass unchanged;
// others get the brightness offset, then the contrast factor around 128.
// A request passes the input stage and then the output register to o_pix.
// Throughput: one pixel per cycle unless stalled, set by the two-register
// pipeline (input stage, then output register), one multiplier per channel.
// Configuration: i_cfg_we/i_cfg_index/i_cfg_data, written while idle.
// Writing contrast_level starts the bit-serial factor divider; for levels
// between -254 and 258 it works out the factor bit by bit with i_pix.ready
// low. Other levels set the factor directly, without the divider.
// Reset (synchronous, i_rst_n low) empties the pipeline, sets the factor to
// 1.0, offset 0, contrast 0, size 640x480.
// When o_pix is stalled the output register holds its result; the input stage
// can still take one more request, after which i_pix.ready drops.
module pixel_brightness_contrast #(
    parameter int MAX_DIMENSION        = pbc_pkg::DEF_MAX_DIMENSION,
    parameter int FACTOR_FRACTION_BITS = pbc_pkg::DEF_FRACTION_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    pbc_stream_if.sink                        i_pix,
    pbc_stream_if.source                      o_pix
);

    localparam int FW    = pbc_pkg::FACTOR_INT_BITS + FACTOR_FRACTION_BITS;
    localparam int PIX_W = pbc_pkg::PIX_W;
    localparam int DIM_W = pbc_pkg::DIM_W;
    localparam logic [DIM_W-1:0] DIM_CAP =
        DIM_W'((MAX_DIMENSION > (2**DIM_W - 1)) ? (2**DIM_W - 1) : MAX_DIMENSION);

    logic [pbc_pkg::OFFS_W-1:0] r_bright;
    logic [DIM_W-1:0]           r_width;
    logic [DIM_W-1:0]           r_height;

    logic                       div_start;
    logic                       div_busy;
    logic [FW-1:0]              factor;

    logic                       r_v1;
    logic                       r_s1_border;
    logic [PIX_W-1:0]           r_s1_val [3];
    logic                       r_v2;
    pbc_pkg::t_pix_out          r_out;

    logic                       en1;
    logic                       en2;
    logic                       take;
    logic [DIM_W-1:0]           w_eff;
    logic [DIM_W-1:0]           h_eff;
    logic [DIM_W-1:0]           col_p1;
    logic [DIM_W-1:0]           row_p1;
    logic                       border;
    logic [PIX_W-1:0]           raw [3];
    logic signed [PIX_W+1:0]    sum [3];
    logic [PIX_W-1:0]           n_s1_val [3];
    logic [PIX_W-1:0]           contr [3];

    // configuration
    assign div_start = i_cfg_we && (pbc_pkg::t_cfg_idx'(i_cfg_index) == pbc_pkg::CFG_CONTRAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= '0;
            r_width  <= pbc_pkg::RESET_WIDTH;
            r_height <= pbc_pkg::RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (pbc_pkg::t_cfg_idx'(i_cfg_index))
                pbc_pkg::CFG_BRIGHTNESS: r_bright <= i_cfg_data[pbc_pkg::OFFS_W-1:0];
                pbc_pkg::CFG_WIDTH:      r_width  <= i_cfg_data[DIM_W-1:0];
                pbc_pkg::CFG_HEIGHT:     r_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    pbc_factor_div #(
        .FRACTION_BITS (FACTOR_FRACTION_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_level  (i_cfg_data[pbc_pkg::LEVEL_W-1:0]),
        .o_busy   (div_busy),
        .o_factor (factor)
    );

    // handshake
    assign en2         = !r_v2 || o_pix.ready;
    assign en1         = !r_v1 || en2;
    assign i_pix.ready = en1 && !div_busy;
    assign take        = i_pix.valid && i_pix.ready;

    // input stage: border test and brightness
    always_comb begin
        w_eff  = (r_width  > DIM_CAP) ? DIM_CAP : r_width;
        h_eff  = (r_height > DIM_CAP) ? DIM_CAP : r_height;
        col_p1 = {1'b0, i_pix.payload.column} + DIM_W'(1);
        row_p1 = {1'b0, i_pix.payload.row} + DIM_W'(1);
        border = (i_pix.payload.column == '0) || (i_pix.payload.row == '0) ||
                 (col_p1 >= w_eff) || (row_p1 >= h_eff);
        raw[0] = i_pix.payload.pixel_red;
        raw[1] = i_pix.payload.pixel_green;
        raw[2] = i_pix.payload.pixel_blue;
        for (int k = 0; k < 3; k++) begin
            sum[k] = $signed({2'b00, raw[k]}) + $signed({r_bright[pbc_pkg::OFFS_W-1], r_bright});
            if (border) begin
                n_s1_val[k] = raw[k];
            end else if (sum[k] < 0) begin
                n_s1_val[k] = '0;
            end else if (sum[k] > $signed({2'b00, pbc_pkg::PIX_MAX})) begin
                n_s1_val[k] = pbc_pkg::PIX_MAX;
            end else begin
                n_s1_val[k] = sum[k][PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= take;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && take) begin
            r_s1_border <= border;
            r_s1_val    <= n_s1_val;
        end
    end

    // contrast stage
    for (genvar k = 0; k < 3; k++) begin : g_chan
        pbc_chan_contrast #(
            .FRACTION_BITS (FACTOR_FRACTION_BITS)
        ) u_chan (
            .i_value  (r_s1_val[k]),
            .i_factor (factor),
            .o_value  (contr[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_out.out_red   <= r_s1_border ? r_s1_val[0] : contr[0];
            r_out.out_green <= r_s1_border ? r_s1_val[1] : contr[1];
            r_out.out_blue  <= r_s1_border ? r_s1_val[2] : contr[2];
        end
    end

    assign o_pix.valid   = r_v2;
    assign o_pix.payload = r_out;

endmodule

// ----- rtl/pbc_checker.sv -----
`timescale 1ns / 1ps
`include "pixel_brightness_contrast_macros.svh"
module pbc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [pbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [pbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input pbc_pkg::t_pix_in               i_in_payload,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input pbc_pkg::t_pix_out              i_out_payload
);

    logic in_take;
    logic slow_contrast;

    assign in_take = i_in_valid && i_in_ready;
    // levels that need the divider rather than a fixed factor
    assign slow_contrast = i_cfg_we &&
        (pbc_pkg::t_cfg_idx'(i_cfg_index) == pbc_pkg::CFG_CONTRAST) &&
        ($signed(i_cfg_data[pbc_pkg::LEVEL_W-1:0]) > -10'sd255) &&
        ($signed(i_cfg_data[pbc_pkg::LEVEL_W-1:0]) < 10'sd259);

    `PBC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload), "result dropped or changed while stalled")
    `PBC_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n) |-> !i_out_valid, "result valid right after reset")
    `PBC_ASSERT(a_div_stall, slow_contrast |=> !i_in_ready, "pixel taken while contrast factor is computed")
    `PBC_ASSERT(a_border_pass, (in_take && i_in_payload.column == '0) ##1 i_out_ready |=> i_out_valid && i_out_payload.out_red == $past(i_in_payload.pixel_red, 2) && i_out_payload.out_blue == $past(i_in_payload.pixel_blue, 2), "border pixel not passed through in two cycles")

endmodule

bind pixel_brightness_contrast pbc_checker u_pbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_in_payload  (i_pix.payload),
    .i_out_valid   (o_pix.valid),
    .i_out_ready   (o_pix.ready),
    .i_out_payload (o_pix.payload)
);

// ----- verif/tb_pixel_brightness_contrast.sv -----
`timescale 1ns / 1ps
module tb_pixel_brightness_contrast;
    import pbc_pkg::*;

    localparam int     FRAC_BITS       = DEF_FRACTION_BITS;
    localparam longint FACTOR_ALL_ONES = (longint'(1) << (FACTOR_INT_BITS + DEF_FRACTION_BITS)) - 1;
    localparam int     PHASES          = 10;
    localparam int     PIXELS_PER_PHASE = 195;
    localparam int     SETTLE_CYCLES   = 4;
    localparam int     RX_HOLD_CYCLES  = 300;
    localparam int     STALL_LIMIT     = 2000;
    localparam int     MAX_PRINTS      = 40;

    // Tracks register copies, predicts each pixel and checks results in order.
    class pixel_scoreboard;
        logic signed [OFFS_W-1:0]  offset = '0;
        logic signed [LEVEL_W-1:0] level  = '0;
        logic [DIM_W-1:0]          width  = RESET_WIDTH;
        logic [DIM_W-1:0]          height = RESET_HEIGHT;
        longint                    factor = longint'(1) << FRAC_BITS;
        t_pix_out                  expected_pixels[$];
        int                        errors   = 0;
        int                        checked  = 0;
        int                        interior = 0;

        function longint factor_for(int c);
            longint num;
            longint den;
            longint q;
            if (c <= -CONTRAST_DEN_K) return 0;
            if (c >= CONTRAST_NUM_K) return FACTOR_ALL_ONES;
            num = longint'(CONTRAST_NUM_K * (c + CONTRAST_DEN_K)) << FRAC_BITS;
            den = longint'(CONTRAST_DEN_K * (CONTRAST_NUM_K - c));
            q = num / den;
            return (q > FACTOR_ALL_ONES) ? FACTOR_ALL_ONES : q;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BRIGHTNESS: offset = data[OFFS_W-1:0];
                CFG_CONTRAST: begin
                    level  = data[LEVEL_W-1:0];
                    factor = factor_for(int'(level));
                end
                CFG_WIDTH:  width  = data;
                CFG_HEIGHT: height = data;
                default: ;
            endcase
        endfunction

        function longint clamp_pixel(longint v);
            return (v < 0) ? 0 : ((v > PIX_MAX) ? longint'(PIX_MAX) : v);
        endfunction

        // brightness then contrast around mid level; negative side rounds down
        function logic [PIX_W-1:0] adjust_channel(logic [PIX_W-1:0] ch);
            longint v;
            longint r;
            longint mag;
            v = clamp_pixel(longint'(ch) + longint'(offset)) - longint'(MID_LEVEL);
            if (v >= 0) begin
                r = (factor * v) >>> FRAC_BITS;
            end else begin
                mag = factor * (-v);
                r = -((mag + (longint'(1) << FRAC_BITS) - 1) >>> FRAC_BITS);
            end
            return PIX_W'(clamp_pixel(r + longint'(MID_LEVEL)));
        endfunction

        function void note_request(t_pix_in p);
            longint   w;
            longint   h;
            t_pix_out want;
            w = (width > DEF_MAX_DIMENSION) ? DEF_MAX_DIMENSION : longint'(width);
            h = (height > DEF_MAX_DIMENSION) ? DEF_MAX_DIMENSION : longint'(height);
            if (p.column == 0 || p.row == 0 || longint'(p.column) >= w - 1
                    || longint'(p.row) >= h - 1) begin
                want = '{p.pixel_red, p.pixel_green, p.pixel_blue};
            end else begin
                want = '{adjust_channel(p.pixel_red), adjust_channel(p.pixel_green),
                         adjust_channel(p.pixel_blue)};
                interior++;
            end
            expected_pixels.push_back(want);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("pixel %0d %s: got %0d, want %0d",
                                          checked, name, got, want));
        endtask

        task check_result(t_pix_out got);
            t_pix_out want;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result %h with no request outstanding", got));
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red", got.out_red, want.out_red);
            compare_field("green", got.out_green, want.out_green);
            compare_field("blue", got.out_blue, want.out_blue);
            checked++;
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pbc_stream_if #(.t_payload(t_pix_in))  pix_req ();
    pbc_stream_if #(.t_payload(t_pix_out)) pix_res ();

    pixel_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_seq;
    int rx_hold_seen;
    int rx_hold_left;
    int stall_cycles;
    int settings_count;

    pixel_brightness_contrast dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_req),
        .o_pix       (pix_res)
    );

    always #6 i_clk = ~i_clk;

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_seq != rx_hold_seen) begin
            rx_hold_seen  <= rx_hold_seq;
            rx_hold_left  <= RX_HOLD_CYCLES;
            pix_res.ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            pix_res.ready <= 1'b0;
        end else begin
            pix_res.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_req.valid && pix_req.ready) sb.note_request(pix_req.payload);
            if (pix_res.valid && pix_res.ready) sb.check_result(pix_res.payload);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_req.valid && pix_req.ready) || (pix_res.valid && pix_res.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_pixel(input t_pix_in p);
        while ($urandom_range(99) < tx_idle_pct) begin
            pix_req.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_req.valid   <= 1'b1;
        pix_req.payload <= p;
        do @(posedge i_clk); while (!pix_req.ready);
    endtask

    // stop offering and wait until every expected result is back
    task automatic drain();
        pix_req.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // contrast goes last: it starts the factor divider
    task automatic write_config(input int offs, input int lvl, input int w, input int h);
        drain();
        cfg_write(CFG_BRIGHTNESS, CFG_DATA_W'(offs));
        cfg_write(CFG_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_HEIGHT, CFG_DATA_W'(h));
        cfg_write(CFG_CONTRAST, CFG_DATA_W'(lvl));
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    function automatic logic [PIX_W-1:0] pick_channel();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return '0;
        if (sel < 20) return PIX_MAX;
        return PIX_W'($urandom_range(255));
    endfunction

    // mostly inside the image, some on the frame, some anywhere
    function automatic logic [COORD_W-1:0] pick_coord(logic [DIM_W-1:0] dim);
        int span;
        int sel;
        span = (dim > DEF_MAX_DIMENSION) ? DEF_MAX_DIMENSION : int'(dim);
        sel = $urandom_range(99);
        if (span < 3 || sel < 10) return COORD_W'($urandom_range(4095));
        if (sel < 25) begin
            case ($urandom_range(3))
                0: return '0;
                1: return COORD_W'(span - 2);
                2: return COORD_W'(span - 1);
                default: return COORD_W'(span);
            endcase
        end
        return COORD_W'($urandom_range(span - 2, 1));
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(9))
            0: return DEF_MAX_DIMENSION;
            1: return $urandom_range(8191);
            2: return $urandom_range(2);
            default: return $urandom_range(64, 3);
        endcase
    endfunction

    initial begin
        t_pix_in p;
        int      offs;
        int      lvl;

        sb = new;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_BRIGHTNESS;
        i_cfg_data      = '0;
        pix_req.valid   = 1'b0;
        pix_req.payload = '0;
        pix_res.ready   = 1'b0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        rx_hold_seq     = 0;
        rx_hold_seen    = 0;
        rx_hold_left    = 0;
        stall_cycles    = 0;
        settings_count  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: unity factor, no offset, 640x480
        send_pixel(t_pix_in'{8'd255, 8'd0, 8'd128, 12'd0, 12'd0});
        send_pixel(t_pix_in'{8'd1, 8'd2, 8'd3, 12'd639, 12'd5});
        send_pixel(t_pix_in'{8'd200, 8'd100, 8'd50, 12'd5, 12'd479});
        send_pixel(t_pix_in'{8'd0, 8'd255, 8'd128, 12'd638, 12'd478});
        send_pixel(t_pix_in'{8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095});
        send_pixel(t_pix_in'{8'd17, 8'd129, 8'd127, 12'd1, 12'd1});
        // most negative offset, zero factor
        write_config(-256, -255, 640, 480);
        send_pixel(t_pix_in'{8'd255, 8'd255, 8'd255, 12'd10, 12'd10});
        send_pixel(t_pix_in'{8'd9, 8'd8, 8'd7, 12'd0, 12'd10});
        // largest factor that comes from the division
        write_config(255, 258, 4096, 4096);
        send_pixel(t_pix_in'{8'd0, 8'd1, 8'd255, 12'd4094, 12'd4094});
        send_pixel(t_pix_in'{8'd0, 8'd1, 8'd255, 12'd4095, 12'd10});
        // level past the divisor pole, sizes above the maximum
        write_config(-1, 259, 8191, 5000);
        send_pixel(t_pix_in'{8'd127, 8'd128, 8'd129, 12'd4094, 12'd4094});
        send_pixel(t_pix_in'{8'd130, 8'd200, 8'd0, 12'd2048, 12'd100});
        // smallest image with an interior pixel
        write_config(0, 0, 3, 3);
        send_pixel(t_pix_in'{8'd50, 8'd60, 8'd70, 12'd1, 12'd1});
        send_pixel(t_pix_in'{8'd50, 8'd60, 8'd70, 12'd2, 12'd1});
        // degenerate sizes: everything on the frame
        write_config(100, -512, 2, 0);
        send_pixel(t_pix_in'{8'd1, 8'd2, 8'd3, 12'd1, 12'd1});
        send_pixel(t_pix_in'{8'd250, 8'd251, 8'd252, 12'd100, 12'd200});
        write_config(-1, 511, 1, 4096);
        send_pixel(t_pix_in'{8'd128, 8'd129, 8'd127, 12'd1, 12'd1});
        write_config(50, 100, 64, 48);
        send_pixel(t_pix_in'{8'd0, 8'd128, 8'd255, 12'd32, 12'd24});
        send_pixel(t_pix_in'{8'd205, 8'd206, 8'd77, 12'd62, 12'd46});
        send_pixel(t_pix_in'{8'd1, 8'd1, 8'd1, 12'd63, 12'd46});
        write_config(-37, -200, 8, 8);
        send_pixel(t_pix_in'{8'd255, 8'd0, 8'd90, 12'd3, 12'd3});
        send_pixel(t_pix_in'{8'd128, 8'd127, 8'd0, 12'd6, 12'd6});
        send_pixel(t_pix_in'{8'd160, 8'd96, 8'd255, 12'd7, 12'd7});

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(9))
                0: offs = -256;
                1: offs = 255;
                2: offs = 0;
                default: offs = int'($urandom_range(511)) - 256;
            endcase
            case ($urandom_range(9))
                0: lvl = -255;
                1: lvl = 258;
                2: lvl = int'($urandom_range(1023)) - 512;
                3, 4: lvl = int'($urandom_range(513)) - 255;
                default: lvl = int'($urandom_range(200)) - 100;
            endcase
            write_config(offs, lvl, pick_dim(), pick_dim());
            if (ph < 3) begin
                tx_idle_pct = 28;
                rx_idle_pct <= 57;
            end else if (ph < 6) begin
                tx_idle_pct = 57;
                rx_idle_pct <= 28;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
                // long receiver hold-off while pixels keep coming: fills the pipe
                if (ph == 1 && k == 60) rx_hold_seq <= rx_hold_seq + 1;
                if (ph == 4 && k == 100) drain();
                p.pixel_red   = pick_channel();
                p.pixel_green = pick_channel();
                p.pixel_blue  = pick_channel();
                p.column      = pick_coord(sb.width);
                p.row         = pick_coord(sb.height);
                send_pixel(p);
            end
        end

        drain();
        $display("Covered %0d pixels (%0d interior) over %0d register settings,",
                 sb.checked, sb.interior, settings_count);
        $display("including degenerate and oversized frames and saturated contrast.");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pbc_pkg.sv
rtl/pbc_stream_if.sv
rtl/pbc_factor_div.sv
rtl/pbc_chan_contrast.sv
rtl/pixel_brightness_contrast.sv
rtl/pbc_checker.sv
verif/tb_pixel_brightness_contrast.sv
